// ===== src/pbsm_pkg.sv =====
// pbsm_pkg: shared types and codes for the polled bus sweep master.
// Holds the input item and result beat structs, operation, event, status,
// frame kind and register index codes. No dependencies.
`default_nettype none

package pbsm_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_FRAME = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_ARM   = 2'd3;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_REPORT  = 2'd1;
    localparam logic [1:0] EV_MISSING = 2'd2;
    localparam logic [1:0] EV_DONE    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BUSY   = 2'd1;
    localparam logic [1:0] ST_NOPODS = 2'd2;

    localparam logic SK_POLL = 1'b0;
    localparam logic SK_ARM  = 1'b1;

    localparam logic [1:0] CFG_POD_COUNT = 2'd0;
    localparam logic [1:0] CFG_POD_ADDRS = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd2;
    localparam logic [1:0] CFG_GAP       = 2'd3;

    localparam logic [7:0] MISS_MAX = 8'd255;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] now_ms;
        logic [7:0]  frame_addr;
        logic        frame_is_report;
        logic [7:0]  target_addr;
        logic        arm_flag;
    } t_item;

    typedef struct packed {
        logic [1:0] event_res;
        logic [2:0] pod_index;
        logic [1:0] status;
        logic       send_valid;
        logic [7:0] send_addr;
        logic       send_kind;
        logic [7:0] send_payload;
        logic       sweep_active;
        logic       pod_present;
        logic [7:0] pod_misses;
    } t_result;

    function automatic logic [7:0] pod_addr(input logic [63:0] addrs, input logic [2:0] idx);
        pod_addr = addrs[{idx, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== src/pbsm_step.sv =====
// pbsm_step: sweep state, per-pod presence and miss counts, register file,
// and the single-pass next-state and result logic for one item.
// Depends on pbsm_pkg.
`default_nettype none

module pbsm_step
    import pbsm_pkg::*;
#(
    parameter int MAX_PODS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_fire,
    input  wire t_item       i_item,
    output t_result          o_result
);

    localparam int SW = (MAX_PODS > 1) ? $clog2(MAX_PODS) : 1;
    localparam logic [3:0]    MAXP = 4'(MAX_PODS);
    localparam logic [SW-1:0] LAST = SW'(MAX_PODS - 1);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_GAP  = 2'd2
    } t_phase;

    logic [3:0]          r_pod_count;
    logic [63:0]         r_addrs;
    logic [15:0]         r_timeout;
    logic [15:0]         r_gap;

    t_phase              r_phase, n_phase;
    logic [3:0]          r_cur, n_cur;
    logic [7:0]          r_seq, n_seq;
    logic [31:0]         r_start, n_start;
    logic [MAX_PODS-1:0] r_present, n_present;
    logic [7:0]          r_miss [MAX_PODS];
    logic [7:0]          n_miss [MAX_PODS];

    logic [3:0]          eff;
    logic [SW-1:0]       slot;
    logic [7:0]          slot_addr;
    logic [31:0]         elapsed;
    logic [7:0]          miss_inc;
    logic                do_poll;
    logic [7:0]          poll_addr;
    t_result             res;

    assign eff       = (r_pod_count > MAXP) ? MAXP : r_pod_count;
    assign slot      = (r_cur < MAXP) ? r_cur[SW-1:0] : LAST;
    assign slot_addr = pod_addr(r_addrs, 3'(slot));
    assign elapsed   = i_item.now_ms - r_start;
    assign miss_inc  = (r_miss[slot] == MISS_MAX) ? MISS_MAX : r_miss[slot] + 8'd1;

    always_comb begin
        res       = '0;
        n_phase   = r_phase;
        n_cur     = r_cur;
        n_seq     = r_seq;
        n_start   = r_start;
        n_present = r_present;
        n_miss    = r_miss;
        do_poll   = 1'b0;
        poll_addr = '0;
        case (i_item.operation)
            OP_START: begin
                if (r_phase != PH_IDLE) begin
                    res.status = ST_BUSY;
                end else if (eff == 4'd0) begin
                    res.status = ST_NOPODS;
                end else begin
                    n_cur     = 4'd0;
                    do_poll   = 1'b1;
                    poll_addr = pod_addr(r_addrs, 3'd0);
                end
            end
            OP_FRAME: begin
                if (r_phase == PH_WAIT && i_item.frame_addr == slot_addr
                        && i_item.frame_is_report) begin
                    n_present[slot] = 1'b1;
                    n_miss[slot]    = 8'd0;
                    res.event_res   = EV_REPORT;
                    res.pod_index   = 3'(slot);
                    res.pod_present = 1'b1;
                    res.pod_misses  = 8'd0;
                    n_cur           = r_cur + 4'd1;
                    n_phase         = PH_GAP;
                    n_start         = i_item.now_ms;
                end
            end
            OP_TICK: begin
                if (r_phase == PH_WAIT) begin
                    if (elapsed >= {16'd0, r_timeout}) begin
                        n_present[slot] = 1'b0;
                        n_miss[slot]    = miss_inc;
                        res.event_res   = EV_MISSING;
                        res.pod_index   = 3'(slot);
                        res.pod_present = 1'b0;
                        res.pod_misses  = miss_inc;
                        n_cur           = r_cur + 4'd1;
                        n_phase         = PH_GAP;
                        n_start         = i_item.now_ms;
                    end
                end else if (r_phase == PH_GAP) begin
                    if (elapsed >= {16'd0, r_gap}) begin
                        if (r_cur >= eff) begin
                            n_phase       = PH_IDLE;
                            res.event_res = EV_DONE;
                        end else begin
                            do_poll   = 1'b1;
                            poll_addr = pod_addr(r_addrs, r_cur[2:0]);
                        end
                    end
                end
            end
            default: begin
                if (r_phase != PH_IDLE) begin
                    res.status = ST_BUSY;
                end else begin
                    res.send_valid   = 1'b1;
                    res.send_addr    = i_item.target_addr;
                    res.send_kind    = SK_ARM;
                    res.send_payload = {7'd0, i_item.arm_flag};
                end
            end
        endcase
        if (do_poll) begin
            res.send_valid   = 1'b1;
            res.send_addr    = poll_addr;
            res.send_kind    = SK_POLL;
            res.send_payload = r_seq;
            n_seq            = r_seq + 8'd1;
            n_phase          = PH_WAIT;
            n_start          = i_item.now_ms;
        end
        res.sweep_active = (n_phase != PH_IDLE);
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pod_count <= '0;
            r_addrs     <= '0;
            r_timeout   <= '0;
            r_gap       <= '0;
            r_phase     <= PH_IDLE;
            r_cur       <= '0;
            r_seq       <= '0;
            r_start     <= '0;
            r_present   <= '0;
            for (int k = 0; k < MAX_PODS; k++) begin
                r_miss[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POD_COUNT: r_pod_count <= i_cfg_data[3:0];
                    CFG_POD_ADDRS: r_addrs     <= i_cfg_data;
                    CFG_TIMEOUT:   r_timeout   <= i_cfg_data[15:0];
                    CFG_GAP:       r_gap       <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_fire) begin
                r_phase   <= n_phase;
                r_cur     <= n_cur;
                r_seq     <= n_seq;
                r_start   <= n_start;
                r_present <= n_present;
                r_miss    <= n_miss;
            end
        end
    end

    a_cur_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= MAXP)
        else $error("pod cursor beyond pod table");

    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.send_valid && res.send_kind == SK_POLL
        |=> r_seq == $past(r_seq) + 8'd1)
        else $error("poll sent without sequence advance");

    a_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.event_res == EV_MISSING
        |=> r_phase == PH_GAP && r_present[$past(slot)] == 1'b0
            && r_miss[$past(slot)] != 8'd0)
        else $error("missing pod not recorded");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_phase == PH_IDLE |-> res.event_res == EV_NONE)
        else $error("event raised while idle");

endmodule

`default_nettype wire

// ===== src/polled_bus_sweep_master.sv =====
// polled_bus_sweep_master: top level with input register and result
// register around pbsm_step. Depends on pbsm_pkg and pbsm_step.
//
// Usage: items enter on i_valid/o_stall (start, received frame, ms tick,
// arm), one result beat leaves per item on o_valid/i_stall. A result with
// o_send_valid set asks for a poll or arm frame on the bus; o_event_res
// reports a pod reply, a missing pod or the end of a sweep.
// Registers are written through i_cfg_we/i_cfg_index/i_cfg_data; the
// user must write them only while idle, the block does not enforce it.
// Throughput: one item per cycle while the receiver does not stall.
// Reset: sweep idle, all registers, presence marks and miss counts zero,
// both pipeline stages empty.
// Receiver stall: the result register holds; the input register fills
// and then o_stall rises until the result beat is taken.
`default_nettype none

module polled_bus_sweep_master
    import pbsm_pkg::*;
#(
    parameter int MAX_PODS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_now_ms,
    input  wire logic [7:0]  i_frame_addr,
    input  wire logic        i_frame_is_report,
    input  wire logic [7:0]  i_target_addr,
    input  wire logic        i_arm_flag,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_event_res,
    output logic [2:0]       o_pod_index,
    output logic [1:0]       o_status,
    output logic             o_send_valid,
    output logic [7:0]       o_send_addr,
    output logic             o_send_kind,
    output logic [7:0]       o_send_payload,
    output logic             o_sweep_active,
    output logic             o_pod_present,
    output logic [7:0]       o_pod_misses
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result step_res;
    logic    out_ready;
    logic    fire;

    assign out_ready = !r_out_valid || !i_stall;
    assign fire      = r_in_valid && out_ready;
    assign o_stall   = r_in_valid && !out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_ready) begin
                r_out_valid <= fire;
            end
        end
        if (i_valid && !o_stall) begin
            r_in.operation       <= i_operation;
            r_in.now_ms          <= i_now_ms;
            r_in.frame_addr      <= i_frame_addr;
            r_in.frame_is_report <= i_frame_is_report;
            r_in.target_addr     <= i_target_addr;
            r_in.arm_flag        <= i_arm_flag;
        end
        if (fire) begin
            r_out <= step_res;
        end
    end

    pbsm_step #(
        .MAX_PODS (MAX_PODS)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_item      (r_in),
        .o_result    (step_res)
    );

    assign o_valid        = r_out_valid;
    assign o_event_res    = r_out.event_res;
    assign o_pod_index    = r_out.pod_index;
    assign o_status       = r_out.status;
    assign o_send_valid   = r_out.send_valid;
    assign o_send_addr    = r_out.send_addr;
    assign o_send_kind    = r_out.send_kind;
    assign o_send_payload = r_out.send_payload;
    assign o_sweep_active = r_out.sweep_active;
    assign o_pod_present  = r_out.pod_present;
    assign o_pod_misses   = r_out.pod_misses;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking bench for polled_bus_sweep_master. A scoreboard class
// predicts every result beat from the accepted input beats and checks them in
// order. Depends on pbsm_pkg and the RTL top level.
module tb
    import pbsm_pkg::*;
();

    localparam int IDLE_LIMIT = 2000;

    typedef enum logic [1:0] {SW_IDLE, SW_WAIT, SW_GAP} t_sweep_phase;

    class sweep_scoreboard;
        logic [3:0]   pod_count;
        logic [63:0]  pod_addrs;
        logic [15:0]  reply_timeout;
        logic [15:0]  gap_ms;
        t_sweep_phase phase;
        logic [3:0]   cur_pod;
        logic [7:0]   seq_no;
        logic [31:0]  phase_t0;
        logic         present_mark [8];
        logic [7:0]   miss_count [8];
        t_result      pending [$];
        t_result      nxt;
        int           mismatches;

        function new();
            pod_count = '0;
            pod_addrs = '0;
            reply_timeout = '0;
            gap_ms = '0;
            phase = SW_IDLE;
            cur_pod = '0;
            seq_no = '0;
            phase_t0 = '0;
            for (int i = 0; i < 8; i++) begin
                present_mark[i] = 1'b0;
                miss_count[i] = '0;
            end
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] d);
            case (idx)
                CFG_POD_COUNT: pod_count = d[3:0];
                CFG_POD_ADDRS: pod_addrs = d;
                CFG_TIMEOUT:   reply_timeout = d[15:0];
                CFG_GAP:       gap_ms = d[15:0];
                default: ;
            endcase
        endfunction

        function logic [3:0] pods_in_sweep();
            return (pod_count > 4'd8) ? 4'd8 : pod_count;
        endfunction

        function logic [2:0] cur_slot();
            return (cur_pod > 4'd7) ? 3'd7 : cur_pod[2:0];
        endfunction

        function logic [7:0] addr_of(logic [2:0] i);
            return pod_addrs[i * 8 +: 8];
        endfunction

        function void send_poll(logic [2:0] i, logic [31:0] now);
            nxt.send_valid = 1'b1;
            nxt.send_addr = addr_of(i);
            nxt.send_kind = SK_POLL;
            nxt.send_payload = seq_no;
            seq_no = seq_no + 8'd1;
            phase = SW_WAIT;
            phase_t0 = now;
        endfunction

        function void close_pod(logic [1:0] ev, logic [2:0] p, logic [31:0] now);
            nxt.event_res = ev;
            nxt.pod_index = p;
            nxt.pod_present = present_mark[p];
            nxt.pod_misses = miss_count[p];
            cur_pod = cur_pod + 4'd1;
            phase = SW_GAP;
            phase_t0 = now;
        endfunction

        function void note_item(t_item it);
            logic [31:0] elapsed;
            logic [2:0]  p;
            nxt = '0;
            elapsed = it.now_ms - phase_t0;
            p = cur_slot();
            case (it.operation)
                OP_START: begin
                    if (phase != SW_IDLE) begin
                        nxt.status = ST_BUSY;
                    end else if (pods_in_sweep() == 4'd0) begin
                        nxt.status = ST_NOPODS;
                    end else begin
                        cur_pod = '0;
                        send_poll(3'd0, it.now_ms);
                    end
                end
                OP_FRAME: begin
                    if (phase == SW_WAIT && it.frame_is_report
                            && it.frame_addr == addr_of(p)) begin
                        present_mark[p] = 1'b1;
                        miss_count[p] = '0;
                        close_pod(EV_REPORT, p, it.now_ms);
                    end
                end
                OP_TICK: begin
                    if (phase == SW_WAIT) begin
                        if (elapsed >= {16'd0, reply_timeout}) begin
                            present_mark[p] = 1'b0;
                            if (miss_count[p] != MISS_MAX)
                                miss_count[p] = miss_count[p] + 8'd1;
                            close_pod(EV_MISSING, p, it.now_ms);
                        end
                    end else if (phase == SW_GAP && elapsed >= {16'd0, gap_ms}) begin
                        if (cur_pod >= pods_in_sweep()) begin
                            phase = SW_IDLE;
                            nxt.event_res = EV_DONE;
                        end else begin
                            send_poll(cur_pod[2:0], it.now_ms);
                        end
                    end
                end
                OP_ARM: begin
                    if (phase != SW_IDLE) begin
                        nxt.status = ST_BUSY;
                    end else begin
                        nxt.send_valid = 1'b1;
                        nxt.send_addr = it.target_addr;
                        nxt.send_kind = SK_ARM;
                        nxt.send_payload = {7'd0, it.arm_flag};
                    end
                end
                default: ;
            endcase
            nxt.sweep_active = (phase != SW_IDLE);
            pending.push_back(nxt);
        endfunction

        function string show(t_result b);
            return $sformatf({"ev %0d pod %0d st %0d send %0d/%02h/%0d/%02h",
                              " active %0d present %0d misses %0d"},
                             b.event_res, b.pod_index, b.status, b.send_valid,
                             b.send_addr, b.send_kind, b.send_payload,
                             b.sweep_active, b.pod_present, b.pod_misses);
        endfunction

        function void check_beat(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result beat: %s", show(got));
                mismatches++;
            end else begin
                want = pending.pop_front();
                if (got !== want) begin
                    if (mismatches < 10) begin
                        $display("result mismatch");
                        $display("  expected %s", show(want));
                        $display("  actual   %s", show(got));
                    end
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_POD_COUNT;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_operation = OP_TICK;
    logic [31:0] i_now_ms = '0;
    logic [7:0]  i_frame_addr = '0;
    logic        i_frame_is_report = 1'b0;
    logic [7:0]  i_target_addr = '0;
    logic        i_arm_flag = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_event_res;
    logic [2:0]  o_pod_index;
    logic [1:0]  o_status;
    logic        o_send_valid;
    logic [7:0]  o_send_addr;
    logic        o_send_kind;
    logic [7:0]  o_send_payload;
    logic        o_sweep_active;
    logic        o_pod_present;
    logic [7:0]  o_pod_misses;
    t_result     out_beat;

    sweep_scoreboard sb = new();
    int          n_sent = 0;
    int          send_idle_pct = 28;
    int          recv_stall_pct = 87;
    int          idle_cycles = 0;
    logic [31:0] bus_ms = '0;

    polled_bus_sweep_master u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_operation      (i_operation),
        .i_now_ms         (i_now_ms),
        .i_frame_addr     (i_frame_addr),
        .i_frame_is_report(i_frame_is_report),
        .i_target_addr    (i_target_addr),
        .i_arm_flag       (i_arm_flag),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_event_res      (o_event_res),
        .o_pod_index      (o_pod_index),
        .o_status         (o_status),
        .o_send_valid     (o_send_valid),
        .o_send_addr      (o_send_addr),
        .o_send_kind      (o_send_kind),
        .o_send_payload   (o_send_payload),
        .o_sweep_active   (o_sweep_active),
        .o_pod_present    (o_pod_present),
        .o_pod_misses     (o_pod_misses)
    );

    assign out_beat = {o_event_res, o_pod_index, o_status, o_send_valid, o_send_addr,
                       o_send_kind, o_send_payload, o_sweep_active, o_pod_present,
                       o_pod_misses};

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_beat(out_beat);
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("** polled_bus_sweep_master: FAILED **");
            $finish;
        end
    end

    task automatic send_item(input t_item it);
        send_idle_pct = (n_sent < 440) ? 28 : (n_sent < 880) ? 87 : 0;
        recv_stall_pct = (n_sent < 440) ? 87 : (n_sent < 880) ? 28 : 0;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= it.operation;
        i_now_ms <= it.now_ms;
        i_frame_addr <= it.frame_addr;
        i_frame_is_report <= it.frame_is_report;
        i_target_addr <= it.target_addr;
        i_arm_flag <= it.arm_flag;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_item(it);
        n_sent++;
    endtask

    task automatic drive_op(input logic [1:0] op, input logic [31:0] now,
                            input logic [7:0] faddr, input logic rep,
                            input logic [7:0] taddr, input logic aflag);
        t_item it;
        it.operation = op;
        it.now_ms = now;
        it.frame_addr = faddr;
        it.frame_is_report = rep;
        it.target_addr = taddr;
        it.arm_flag = aflag;
        send_item(it);
    endtask

    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [63:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        sb.write_reg(idx, d);
    endtask

    task automatic configure(input logic [3:0] count, input logic [63:0] addrs,
                             input logic [15:0] timeout_ms, input logic [15:0] gap);
        put_reg(CFG_POD_COUNT, {60'd0, count});
        put_reg(CFG_POD_ADDRS, addrs);
        put_reg(CFG_TIMEOUT, {48'd0, timeout_ms});
        put_reg(CFG_GAP, {48'd0, gap});
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_item next_item(input bit quiet);
        t_item it;
        int    r;
        int    pick;
        r = $urandom_range(0, 99);
        if (r < 3)
            bus_ms = $urandom;
        else if (r < 7)
            bus_ms = bus_ms + $urandom_range(0, 70000);
        else
            bus_ms = bus_ms + $urandom_range(0, 6);
        it.now_ms = bus_ms;
        it.frame_addr = $urandom_range(0, 255);
        it.frame_is_report = $urandom_range(0, 1);
        it.target_addr = $urandom_range(0, 255);
        it.arm_flag = $urandom_range(0, 1);
        pick = $urandom_range(0, 99);
        case (sb.phase)
            SW_IDLE: begin
                if (quiet)
                    it.operation = (pick < 96) ? OP_START : OP_TICK;
                else
                    it.operation = (pick < 50) ? OP_START : (pick < 70) ? OP_ARM :
                                   (pick < 85) ? OP_TICK : OP_FRAME;
            end
            SW_WAIT: begin
                if (pick < (quiet ? 0 : 45)) begin
                    it.operation = OP_FRAME;
                    it.frame_addr = sb.addr_of(sb.cur_slot());
                    it.frame_is_report = 1'b1;
                end else if (pick < (quiet ? 3 : 55)) begin
                    it.operation = OP_FRAME;
                end else begin
                    it.operation = (pick < 97) ? OP_TICK : (pick < 99) ? OP_START : OP_ARM;
                end
            end
            default: begin
                it.operation = (pick < 88) ? OP_TICK : (pick < 94) ? OP_FRAME :
                               (pick < 97) ? OP_START : OP_ARM;
            end
        endcase
        return it;
    endfunction

    task automatic run_phase(input logic [3:0] count, input logic [63:0] addrs,
                             input logic [15:0] timeout_ms, input logic [15:0] gap,
                             input int n_items, input bit quiet);
        wait_results_done();
        configure(count, addrs, timeout_ms, gap);
        repeat (n_items) send_item(next_item(quiet));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        drive_op(OP_START, 32'd0, 8'h00, 1'b0, 8'h00, 1'b0);
        drive_op(OP_ARM, 32'd1, 8'h00, 1'b0, 8'hFF, 1'b1);
        drive_op(OP_ARM, 32'd2, 8'hFF, 1'b1, 8'h00, 1'b0);
        drive_op(OP_TICK, 32'd3, 8'h00, 1'b0, 8'h00, 1'b0);
        drive_op(OP_FRAME, 32'd4, 8'hFF, 1'b1, 8'h00, 1'b0);

        wait_results_done();
        configure(4'd2, 64'h0000_0000_0000_00FF, 16'd5, 16'd3);
        drive_op(OP_START, 32'd100, 8'h00, 1'b0, 8'h00, 1'b0);
        drive_op(OP_START, 32'd100, 8'h00, 1'b0, 8'h00, 1'b0);
        drive_op(OP_ARM, 32'd100, 8'h00, 1'b0, 8'h5A, 1'b1);
        drive_op(OP_FRAME, 32'd101, 8'h12, 1'b1, 8'h00, 1'b0);
        drive_op(OP_FRAME, 32'd102, 8'hFF, 1'b0, 8'h00, 1'b0);
        drive_op(OP_TICK, 32'd104, 8'h00, 1'b0, 8'h00, 1'b0);
        drive_op(OP_FRAME, 32'd104, 8'hFF, 1'b1, 8'h00, 1'b0);
        drive_op(OP_FRAME, 32'd105, 8'hFF, 1'b1, 8'h00, 1'b0);
        drive_op(OP_TICK, 32'd106, 8'h00, 1'b0, 8'h00, 1'b0);
        drive_op(OP_TICK, 32'd107, 8'h00, 1'b0, 8'h00, 1'b0);
        drive_op(OP_TICK, 32'd112, 8'h00, 1'b0, 8'h00, 1'b0);
        drive_op(OP_TICK, 32'd115, 8'h00, 1'b0, 8'h00, 1'b0);
        // sweep across the wrap of the millisecond counter
        drive_op(OP_START, 32'hFFFF_FFFE, 8'h00, 1'b0, 8'h00, 1'b0);
        drive_op(OP_TICK, 32'd2, 8'h00, 1'b0, 8'h00, 1'b0);
        drive_op(OP_TICK, 32'd3, 8'h00, 1'b0, 8'h00, 1'b0);
        drive_op(OP_TICK, 32'd6, 8'h00, 1'b0, 8'h00, 1'b0);
        drive_op(OP_FRAME, 32'd6, 8'h00, 1'b1, 8'h00, 1'b0);
        drive_op(OP_TICK, 32'd9, 8'h00, 1'b0, 8'h00, 1'b0);
        bus_ms = 32'd9;

        run_phase(4'd3, {$urandom, $urandom}, 16'd4, 16'd2, 60, 1'b0);
        run_phase(4'd8, {$urandom, $urandom}, 16'd0, 16'd0, 60, 1'b0);
        // silent pod: drive the miss count into saturation
        run_phase(4'd1, {$urandom, $urandom}, 16'd0, 16'd0, 900, 1'b1);
        run_phase(4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 50, 1'b0);
        run_phase(4'd5, 64'd0, 16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                  40, 1'b0);
        run_phase(4'd0, {$urandom, $urandom}, 16'd3, 16'd3, 15, 1'b0);

        wait_results_done();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("** polled_bus_sweep_master: PASSED **");
        else
            $display("** polled_bus_sweep_master: FAILED **");
        $finish;
    end
endmodule

// ===== polled_bus_sweep_master.f =====
src/pbsm_pkg.sv
src/pbsm_step.sv
src/polled_bus_sweep_master.sv
tb/tb.sv
